// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BBCM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define BBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BBCM_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/bbcm_pkg.sv -----
package bbcm_pkg;

    localparam int MAX_BOXES  = 16;
    localparam int COORD_BITS = 12;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_READOUT = 1'b1;
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   coord_ext_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic       mode;
        coord_t     left;
        coord_t     top;
        coord_t     width;
        coord_t     height;
        coord_ext_t mid_x;
        coord_ext_t mid_y;
        coord_ext_t right;
        coord_ext_t bottom;
    } probe_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              merged;
        logic              dropped;
        logic              entry_valid;
        coord_t            left;
        coord_t            top;
        coord_t            width;
        coord_t            height;
        logic              last;
    } report_t;

endpackage

// ----- hdl/bbcm_cell.sv -----
module bbcm_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bbcm_pkg::CNT_W-1:0] idx,
    input  logic [bbcm_pkg::CNT_W-1:0] count,
    input  bbcm_pkg::probe_t           probe,
    input  logic                       tok_in,
    output logic                       tok_out,
    output bbcm_pkg::report_t          rep
);
    import bbcm_pkg::*;

    coord_t     left_reg;
    coord_t     top_reg;
    coord_t     width_reg;
    coord_t     height_reg;
    coord_t     left_next;
    coord_t     top_next;
    coord_t     width_next;
    coord_t     height_next;
    logic       wr_en;
    logic       tok_reg;

    coord_ext_t sr;
    coord_ext_t sb;
    logic       hit;
    coord_t     ul;
    coord_t     ut;
    coord_ext_t ur;
    coord_ext_t ub;
    coord_ext_t uw_full;
    coord_ext_t uh_full;
    coord_t     uw;
    coord_t     uh;
    logic       occupied;
    logic       at_end;
    logic       is_last;
    logic [CNT_W-1:0] idx_p1;

    always_comb
    begin
        sr  = {1'b0, left_reg} + {1'b0, width_reg};
        sb  = {1'b0, top_reg} + {1'b0, height_reg};
        hit = ({1'b0, left_reg} < probe.mid_x) && (sr > probe.mid_x)
              && ({1'b0, top_reg} < probe.mid_y) && (sb > probe.mid_y);
        ul  = (probe.left < left_reg) ? probe.left : left_reg;
        ut  = (probe.top < top_reg) ? probe.top : top_reg;
        ur  = (probe.right > sr) ? probe.right : sr;
        ub  = (probe.bottom > sb) ? probe.bottom : sb;
        uw_full = ur - {1'b0, ul};
        uh_full = ub - {1'b0, ut};
        uw  = uw_full[COORD_BITS] ? '1 : uw_full[COORD_BITS-1:0];
        uh  = uh_full[COORD_BITS] ? '1 : uh_full[COORD_BITS-1:0];
        occupied = idx < count;
        at_end   = idx == count;
        idx_p1   = idx + CNT_W'(1);
        is_last  = idx_p1 == count;
    end

    always_comb
    begin
        rep         = '0;
        tok_out     = 1'b0;
        wr_en       = 1'b0;
        left_next   = left_reg;
        top_next    = top_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (tok_reg)
        begin
            priority if (probe.mode == MODE_READOUT)
            begin
                rep.valid       = 1'b1;
                rep.kind        = KIND_READOUT;
                rep.slot        = SLOT_W'(idx);
                rep.entry_valid = 1'b1;
                rep.left        = left_reg;
                rep.top         = top_reg;
                rep.width       = width_reg;
                rep.height      = height_reg;
                rep.last        = is_last;
                tok_out         = !is_last;
            end
            else if (occupied)
            begin
                if (hit)
                begin
                    wr_en       = 1'b1;
                    left_next   = ul;
                    top_next    = ut;
                    width_next  = uw;
                    height_next = uh;
                    rep.valid   = 1'b1;
                    rep.kind    = KIND_INSERT;
                    rep.slot    = SLOT_W'(idx);
                    rep.merged  = 1'b1;
                    rep.left    = ul;
                    rep.top     = ut;
                    rep.width   = uw;
                    rep.height  = uh;
                    rep.last    = 1'b1;
                end
                else
                begin
                    tok_out = 1'b1;
                end
            end
            else if (at_end)
            begin
                wr_en       = 1'b1;
                left_next   = probe.left;
                top_next    = probe.top;
                width_next  = probe.width;
                height_next = probe.height;
                rep.valid   = 1'b1;
                rep.kind    = KIND_INSERT;
                rep.slot    = SLOT_W'(idx);
                rep.left    = probe.left;
                rep.top     = probe.top;
                rep.width   = probe.width;
                rep.height  = probe.height;
                rep.last    = 1'b1;
            end
            else
            begin
                tok_out = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

endmodule

// ----- hdl/bbcm_ctrl.sv -----
`include "assert_macros.svh"

module bbcm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       mode,
    input  bbcm_pkg::coord_t           box_left,
    input  bbcm_pkg::coord_t           box_top,
    input  bbcm_pkg::coord_t           box_width,
    input  bbcm_pkg::coord_t           box_height,
    input  bbcm_pkg::report_t          cell_rep,
    input  logic                       chain_end,
    output logic                       busy,
    output logic                       inject,
    output bbcm_pkg::probe_t           probe,
    output logic [bbcm_pkg::CNT_W-1:0] count,
    output bbcm_pkg::report_t          result
);
    import bbcm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    probe_t           probe_reg;
    probe_t           probe_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    report_t          result_reg;
    report_t          result_next;
    report_t          drop_rep;
    report_t          fin;
    logic             accept;
    logic             empty_rd;

    always_comb
    begin
        accept   = start && (state_reg == ST_IDLE);
        empty_rd = accept && (mode == MODE_READOUT) && (count_reg == '0);
        inject   = accept && !empty_rd;

        probe_next.mode   = mode;
        probe_next.left   = box_left;
        probe_next.top    = box_top;
        probe_next.width  = box_width;
        probe_next.height = box_height;
        probe_next.mid_x  = {1'b0, box_left} + {2'b00, box_width[COORD_BITS-1:1]};
        probe_next.mid_y  = {1'b0, box_top} + {2'b00, box_height[COORD_BITS-1:1]};
        probe_next.right  = {1'b0, box_left} + {1'b0, box_width};
        probe_next.bottom = {1'b0, box_top} + {1'b0, box_height};

        // chain ran out with no match and no room
        drop_rep         = '0;
        drop_rep.valid   = chain_end;
        drop_rep.kind    = KIND_INSERT;
        drop_rep.dropped = chain_end;
        drop_rep.left    = chain_end ? probe_reg.left : '0;
        drop_rep.top     = chain_end ? probe_reg.top : '0;
        drop_rep.width   = chain_end ? probe_reg.width : '0;
        drop_rep.height  = chain_end ? probe_reg.height : '0;
        drop_rep.last    = chain_end;

        fin = cell_rep | drop_rep;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (inject)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fin.valid && fin.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg == ST_RUN);
    end

    always_comb
    begin
        result_next = fin;
        if (empty_rd)
        begin
            result_next       = '0;
            result_next.valid = 1'b1;
            result_next.kind  = KIND_READOUT;
            result_next.last  = 1'b1;
        end

        count_next = count_reg;
        if (fin.valid && (fin.kind == KIND_INSERT) && !fin.merged && !fin.dropped)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (fin.valid && (fin.kind == KIND_READOUT) && fin.last)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe  = probe_reg;
    assign count  = count_reg;
    assign result = result_reg;

    `BBCM_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(MAX_BOXES))
    `BBCM_ASSERT_ALWAYS(a_report_in_run, clk, rst_n, !fin.valid || (state_reg == ST_RUN))
    `BBCM_ASSERT_NEXT(a_readout_clears, clk, rst_n,
        fin.valid && (fin.kind == KIND_READOUT) && fin.last, count_reg == '0)
    `BBCM_ASSERT_NEXT(a_inject_runs, clk, rst_n, inject, state_reg == ST_RUN)

endmodule

// ----- hdl/bounding_box_center_merge_core.sv -----
// insert: the result strobes once the token reaches the slot that merges or is
//   appended; a dropped box reports once the token leaves the last cell
// readout: one strobe per stored box in slot order; an empty table gives one strobe
// busy falls as the final result strobes, and start is taken only while not busy;
//   the search token walks the cell chain one cell per cycle
// rst_n clears the box count, state and strobe; stored boxes hold until rewritten
`include "assert_macros.svh"

module bounding_box_center_merge_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [bbcm_pkg::COORD_BITS-1:0]     box_left,
    input  logic [bbcm_pkg::COORD_BITS-1:0]     box_top,
    input  logic [bbcm_pkg::COORD_BITS-1:0]     box_width,
    input  logic [bbcm_pkg::COORD_BITS-1:0]     box_height,
    output logic                                strobe,
    output logic                                kind,
    output logic [bbcm_pkg::SLOT_W-1:0]         slot,
    output logic                                merged,
    output logic                                dropped,
    output logic                                entry_valid,
    output logic [bbcm_pkg::COORD_BITS-1:0]     out_left,
    output logic [bbcm_pkg::COORD_BITS-1:0]     out_top,
    output logic [bbcm_pkg::COORD_BITS-1:0]     out_width,
    output logic [bbcm_pkg::COORD_BITS-1:0]     out_height,
    output logic                                last
);
    import bbcm_pkg::*;

    logic [MAX_BOXES:0] tok;
    report_t            cell_reps [MAX_BOXES];
    report_t            rep_or;
    probe_t             probe;
    logic [CNT_W-1:0]   count;
    report_t            result;

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            bbcm_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (CNT_W'(g)),
                .count   (count),
                .probe   (probe),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1]),
                .rep     (cell_reps[g])
            );
        end
    endgenerate

    always_comb
    begin
        rep_or = '0;
        for (int i = 0; i < MAX_BOXES; i++)
        begin
            rep_or = rep_or | cell_reps[i];
        end
    end

    bbcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .cell_rep   (rep_or),
        .chain_end  (tok[MAX_BOXES]),
        .busy       (busy),
        .inject     (tok[0]),
        .probe      (probe),
        .count      (count),
        .result     (result)
    );

    assign strobe      = result.valid;
    assign kind        = result.kind;
    assign slot        = result.slot;
    assign merged      = result.merged;
    assign dropped     = result.dropped;
    assign entry_valid = result.entry_valid;
    assign out_left    = result.left;
    assign out_top     = result.top;
    assign out_width   = result.width;
    assign out_height  = result.height;
    assign last        = result.last;

    `BBCM_ASSERT_ALWAYS(a_single_token, clk, rst_n, $onehot0(tok))
    `BBCM_ASSERT_ALWAYS(a_no_token_idle, clk, rst_n, busy || (tok[MAX_BOXES:1] == '0))
    `BBCM_ASSERT_NEXT(a_last_frees, clk, rst_n, busy && rep_or.valid && rep_or.last, !busy)

endmodule
